[rtl/tick_counter_to_microseconds_macros.svh]
// ----------------------------------------------------------------------------
// tick_counter_to_microseconds_macros
// Assertion helpers for the tick counter to microseconds block.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef TICK_COUNTER_TO_MICROSECONDS_MACROS_SVH
`define TICK_COUNTER_TO_MICROSECONDS_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define TCUS_ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);

// Condition a implies condition c in the next cycle.
`define TCUS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);

`endif

[rtl/tcus_pkg.sv]
// ----------------------------------------------------------------------------
// tcus_pkg
// Shared types and constants for the tick counter to microseconds block.
// ----------------------------------------------------------------------------
package tcus_pkg;

	localparam int SAMPLE_W = 32;
	localparam int TOTAL_W  = 64;
	localparam int FREQ_W   = 32;
	localparam int MICROS_W = 20;
	localparam int PROD_W   = SAMPLE_W + MICROS_W;
	localparam int STEP_W   = 6;

	localparam logic [MICROS_W-1:0] MICROS_PER_SECOND = 20'd1000000;
	localparam logic [FREQ_W-1:0]   DEFAULT_FREQ      = 32'd709379;
	localparam logic [STEP_W-1:0]   LAST_STEP         = 6'd63;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [TOTAL_W-1:0] scaled;
	} tcus_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tcus_qstat_t;

	typedef enum logic [1:0] {
		BACK_IDLE,
		BACK_DIV,
		BACK_DONE
	} tcus_back_state_t;

endpackage

[rtl/tcus_if.sv]
// ----------------------------------------------------------------------------
// tcus_if
// Valid/ready channels: samples in, results out, frequency writes.
// ----------------------------------------------------------------------------
interface tcus_sample_if;
	logic                          valid;
	logic                          ready;
	logic [tcus_pkg::SAMPLE_W-1:0] counter_sample;

	modport source (output valid, output counter_sample, input ready);
	modport sink   (input valid, input counter_sample, output ready);
endinterface

interface tcus_result_if;
	logic                         valid;
	logic                         ready;
	logic [tcus_pkg::FREQ_W-1:0]  elapsed_micros;
	logic [tcus_pkg::TOTAL_W-1:0] tick_total_out;

	modport source (output valid, output elapsed_micros, output tick_total_out, input ready);
	modport sink   (input valid, input elapsed_micros, input tick_total_out, output ready);
endinterface

interface tcus_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tcus_pkg::FREQ_W-1:0] tick_frequency;

	modport source (output valid, output tick_frequency, input ready);
	modport sink   (input valid, input tick_frequency, output ready);
endinterface

[rtl/tcus_front.sv]
// ----------------------------------------------------------------------------
// tcus_front
// Takes counter samples, extends them to a 64-bit total and keeps the
// scaled total (total * 1e6 mod 2^64) up to date incrementally.
// ----------------------------------------------------------------------------
module tcus_front (
	input  logic                  clk,
	input  logic                  arst_n,
	tcus_sample_if.sink           samples,
	output logic                  push,
	output tcus_pkg::tcus_entry_t push_entry,
	input  tcus_pkg::tcus_qstat_t qstat
);

	logic                           baseline_q;
	logic [tcus_pkg::SAMPLE_W-1:0] prev_q;
	logic [tcus_pkg::TOTAL_W-1:0]  total_q;
	logic [tcus_pkg::TOTAL_W-1:0]  scaled_q;

	logic                           v_s1;
	logic                           first_s1;
	logic [tcus_pkg::SAMPLE_W-1:0] delta_s1;
	logic                           v_s2;
	logic                           first_s2;
	logic [tcus_pkg::PROD_W-1:0]   prod_s2;

	logic                           accept;
	logic [tcus_pkg::TOTAL_W-1:0]  scaled_next;

	assign samples.ready = !v_s1 && !v_s2;
	assign accept        = samples.valid && samples.ready;

	// Scaled total grows by delta * 1e6, wrapping mod 2^64 like the product.
	assign scaled_next = first_s2 ? '0 : scaled_q + tcus_pkg::TOTAL_W'(prod_s2);
	assign push        = v_s2 && !qstat.full;

	always_comb begin
		push_entry.total  = total_q;
		push_entry.scaled = scaled_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q <= 1'b0;
			prev_q     <= '0;
			total_q    <= '0;
			scaled_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			if (accept) begin
				v_s1       <= 1'b1;
				first_s1   <= !baseline_q;
				delta_s1   <= baseline_q ? samples.counter_sample - prev_q : '0;
				prev_q     <= samples.counter_sample;
				baseline_q <= 1'b1;
			end
			if (v_s1) begin
				v_s1     <= 1'b0;
				v_s2     <= 1'b1;
				first_s2 <= first_s1;
				prod_s2  <= {{tcus_pkg::MICROS_W{1'b0}}, delta_s1}
					* {{tcus_pkg::SAMPLE_W{1'b0}}, tcus_pkg::MICROS_PER_SECOND};
				total_q  <= first_s1 ? '0 : total_q + tcus_pkg::TOTAL_W'(delta_s1);
			end
			if (push) begin
				v_s2     <= 1'b0;
				scaled_q <= scaled_next;
			end
		end
	end

endmodule

[rtl/tcus_fifo.sv]
// ----------------------------------------------------------------------------
// tcus_fifo
// Small queue of tick totals and scaled totals between the front and the divider.
// ----------------------------------------------------------------------------
module tcus_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tcus_pkg::tcus_entry_t push_entry,
	input  logic                  pop,
	output tcus_pkg::tcus_entry_t pop_entry,
	output tcus_pkg::tcus_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	tcus_pkg::tcus_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);
	assign pop_entry   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/tcus_back.sv]
// ----------------------------------------------------------------------------
// tcus_back
// Radix-2 restoring divide of the scaled total by the tick frequency,
// one quotient bit per cycle, with a result register on the output.
// ----------------------------------------------------------------------------
module tcus_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tcus_pkg::FREQ_W-1:0] freq,
	output logic                        pop,
	input  tcus_pkg::tcus_entry_t       pop_entry,
	input  tcus_pkg::tcus_qstat_t       qstat,
	tcus_result_if.source               results
);

	tcus_pkg::tcus_back_state_t state_q;
	tcus_pkg::tcus_back_state_t state_d;

	logic [tcus_pkg::TOTAL_W-1:0] dividend_q;
	logic [tcus_pkg::TOTAL_W-1:0] total_q;
	logic [tcus_pkg::FREQ_W-1:0]  divisor_q;
	logic [tcus_pkg::FREQ_W-1:0]  rem_q;
	logic [tcus_pkg::FREQ_W-1:0]  quo_q;
	logic [tcus_pkg::STEP_W-1:0]  step_q;
	logic                          out_v_q;

	logic                          load_out;
	logic [tcus_pkg::FREQ_W:0]     shifted;
	logic [tcus_pkg::FREQ_W:0]     diff;
	logic                          fits;

	assign shifted = {rem_q, dividend_q[tcus_pkg::TOTAL_W-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign fits    = !diff[tcus_pkg::FREQ_W];

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			tcus_pkg::BACK_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = tcus_pkg::BACK_DIV;
				end
			end
			tcus_pkg::BACK_DIV: begin
				if (step_q == '0) begin
					state_d = tcus_pkg::BACK_DONE;
				end
			end
			tcus_pkg::BACK_DONE: begin
				if (!out_v_q || results.ready) begin
					load_out = 1'b1;
					state_d  = tcus_pkg::BACK_IDLE;
				end
			end
			default: state_d = tcus_pkg::BACK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcus_pkg::BACK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dividend_q <= pop_entry.scaled;
			total_q    <= pop_entry.total;
			divisor_q  <= freq;
			rem_q      <= '0;
			quo_q      <= '0;
			step_q     <= tcus_pkg::LAST_STEP;
		end else if (state_q == tcus_pkg::BACK_DIV) begin
			rem_q      <= fits ? diff[tcus_pkg::FREQ_W-1:0] : shifted[tcus_pkg::FREQ_W-1:0];
			quo_q      <= {quo_q[tcus_pkg::FREQ_W-2:0], fits};
			dividend_q <= {dividend_q[tcus_pkg::TOTAL_W-2:0], 1'b0};
			step_q     <= step_q - 1'b1;
		end
		if (load_out) begin
			results.elapsed_micros <= quo_q;
			results.tick_total_out <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign results.valid = out_v_q;

endmodule

[rtl/tick_counter_to_microseconds.sv]
// Flow: the back end divides one sample at a time: a pop, 64 radix-2 divide
//   steps and a result load that waits for the sink; the front and queue take
//   the next sample while a division runs, as long as the queue has room.
// Reset: arst_n clears the baseline, total, queue and divider state at once;
//   tick_frequency returns to 709379. No clearing pass is needed.
// ----------------------------------------------------------------------------
// tick_counter_to_microseconds
// Extends a wrapping 32-bit tick counter to a 64-bit total and converts it
// to elapsed microseconds at the configured tick frequency.
// ----------------------------------------------------------------------------
`include "tick_counter_to_microseconds_macros.svh"

module tick_counter_to_microseconds #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	tcus_sample_if.sink   samples,
	tcus_result_if.source results,
	tcus_cfg_if.sink      cfg
);

	// Frequency register; a zero write falls back to the reset value so the
	// divider never sees a zero divisor.
	logic [tcus_pkg::FREQ_W-1:0] freq_q;

	// Front to queue, queue to back.
	logic                  push;
	logic                  pop;
	tcus_pkg::tcus_entry_t push_entry;
	tcus_pkg::tcus_entry_t pop_entry;
	tcus_pkg::tcus_qstat_t qstat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= tcus_pkg::DEFAULT_FREQ;
		end else if (cfg.valid && cfg.ready) begin
			freq_q <= (cfg.tick_frequency == '0) ? tcus_pkg::DEFAULT_FREQ
				: cfg.tick_frequency;
		end
	end

	// Front: takes the sample transfer, updates previous sample, running total
	// and the scaled total over two short stages, then pushes one entry.
	tcus_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push       (push),
		.push_entry (push_entry),
		.qstat      (qstat)
	);

	// Queue decouples the front from the long division.
	tcus_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	// Back: serial divide and result register; holds the result until the
	// sink takes the transfer.
	tcus_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.freq      (freq_q),
		.pop       (pop),
		.pop_entry (pop_entry),
		.qstat     (qstat),
		.results   (results)
	);

	// Queue never overflows or underflows, and the divisor is never zero.
	`TCUS_ASSERT_IMPLIES(a_push_not_full, clk, arst_n, push, !qstat.full, "push into full queue")
	`TCUS_ASSERT_IMPLIES(a_pop_not_empty, clk, arst_n, pop, !qstat.empty, "pop from empty queue")
	`TCUS_ASSERT_IMPLIES(a_freq_nonzero, clk, arst_n, 1'b1, freq_q != '0, "zero tick frequency")
	`TCUS_ASSERT_NEXT(a_pop_clears_push, clk, arst_n, push && qstat.empty, !qstat.empty || pop, "queued entry lost")

endmodule

[test/tick_counter_to_microseconds_tb.sv]
// ----------------------------------------------------------------------------
// tick_counter_to_microseconds_tb
// Feeds counter samples through the valid/ready channels and checks every
// result field against a cycle-free predictor of the tick total and the
// microsecond quotient. Covers wrap, zero and maximum deltas, frequency
// extremes, zero-frequency substitution and quotient truncation, under
// several idling patterns on both sides.
// ----------------------------------------------------------------------------
module tick_counter_to_microseconds_tb;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_ITEMS  = 280;   // per phase, five phases
	// Maximum-delta samples that push the total up quickly.
	localparam int CLIMB_STEPS   = 100;
	localparam int SETTLE_CYCLES = 80;    // extra wait for a stray result at the end
	localparam int NO_DRAIN      = -1;

	// One expected result, in the order the block sends them.
	typedef struct packed {
		logic [tcus_pkg::FREQ_W-1:0]  micros;
		logic [tcus_pkg::TOTAL_W-1:0] total;
	} micros_result_t;

	// One queued sample; hold_for_empty makes the sender wait until every
	// outstanding result has come back before offering it.
	typedef struct {
		logic [tcus_pkg::SAMPLE_W-1:0] sample;
		bit                            hold_for_empty;
	} sample_item_t;

	logic clk = 1'b0;
	logic arst_n;

	tcus_sample_if samples_ch();
	tcus_result_if results_ch();
	tcus_cfg_if    cfg_ch();

	tick_counter_to_microseconds DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Predictor state, mirrors the block after reset
	logic [tcus_pkg::FREQ_W-1:0]   freq_model        = tcus_pkg::DEFAULT_FREQ;
	logic [tcus_pkg::SAMPLE_W-1:0] last_sample_model = '0;
	logic [tcus_pkg::TOTAL_W-1:0]  total_model       = '0;
	bit                            baseline_model    = 1'b0;

	sample_item_t   pending_samples[$];
	micros_result_t expected_results[$];

	// Transfers seen at the last rising edge; read by the negedge drivers.
	bit sample_fired, result_fired, cfg_fired;

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int errors          = 0;
	int items_queued    = 0;
	int results_checked = 0;

	// Stimulus-side copy of the counter, so random items mostly advance it.
	logic [tcus_pkg::SAMPLE_W-1:0] counter_now = '0;

	// Extend the sample into the running total and scale it. The product
	// wraps at 64 bits before the divide; the quotient keeps its low word.
	function automatic micros_result_t accumulate_ticks(
		input logic [tcus_pkg::SAMPLE_W-1:0] sample);
		micros_result_t                r;
		logic [tcus_pkg::SAMPLE_W-1:0] delta;
		logic [tcus_pkg::TOTAL_W-1:0]  scaled;
		if (!baseline_model) begin
			// first sample only sets the baseline
			baseline_model    = 1'b1;
			last_sample_model = sample;
			total_model       = '0;
			r.micros          = '0;
			r.total           = '0;
			return r;
		end
		delta             = sample - last_sample_model;   // mod 2^32, survives wrap
		last_sample_model = sample;
		total_model       = total_model + tcus_pkg::TOTAL_W'(delta);
		scaled            = total_model * tcus_pkg::TOTAL_W'(tcus_pkg::MICROS_PER_SECOND);
		r.micros          = tcus_pkg::FREQ_W'(scaled / tcus_pkg::TOTAL_W'(freq_model));
		r.total           = total_model;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: all handshakes are sampled here at the rising edge.
	// Results are checked before the new sample is predicted; a result can
	// never belong to a sample taken on the same edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		micros_result_t want;
		sample_fired = arst_n && samples_ch.valid && samples_ch.ready;
		result_fired = arst_n && results_ch.valid && results_ch.ready;
		cfg_fired    = arst_n && cfg_ch.valid && cfg_ch.ready;

		if (result_fired) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual micros %h total %h",
					$time, results_ch.elapsed_micros, results_ch.tick_total_out);
			end else begin
				want = expected_results.pop_front();
				if (results_ch.elapsed_micros !== want.micros) begin
					errors++;
					$display("%0t: elapsed_micros mismatch: expected %h, actual %h",
						$time, want.micros, results_ch.elapsed_micros);
				end
				if (results_ch.tick_total_out !== want.total) begin
					errors++;
					$display("%0t: tick_total_out mismatch: expected %h, actual %h",
						$time, want.total, results_ch.tick_total_out);
				end
			end
			results_checked++;
		end

		// a zero write falls back to the default rate
		if (cfg_fired)
			freq_model = (cfg_ch.tick_frequency == '0) ? tcus_pkg::DEFAULT_FREQ
				: cfg_ch.tick_frequency;

		if (sample_fired)
			expected_results.push_back(accumulate_ticks(samples_ch.counter_sample));
	end

	// ------------------------------------------------------------------
	// Sample driver: offers the next queued sample once the previous one
	// has transferred; valid holds steady while waiting for ready.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : sample_driver
		sample_item_t next_item;
		if (!arst_n) begin
			samples_ch.valid <= 1'b0;
		end else if (!samples_ch.valid || sample_fired) begin
			if (pending_samples.size() != 0
			    && !(pending_samples[0].hold_for_empty && expected_results.size() != 0)
			    && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_samples.pop_front();
				samples_ch.valid          <= 1'b1;
				samples_ch.counter_sample <= next_item.sample;
			end else begin
				samples_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: random backpressure
	always @(negedge clk) begin
		results_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_sample(input logic [tcus_pkg::SAMPLE_W-1:0] sample,
		input bit hold = 1'b0);
		sample_item_t item;
		item.sample         = sample;
		item.hold_for_empty = hold;
		pending_samples.push_back(item);
		items_queued++;
		counter_now = sample;
	endtask

	// Mostly a counter that moves forward by deltas of every size, with some
	// arbitrary jumps mixed in.
	task automatic queue_random_samples(input int count, input int hold_at);
		logic [tcus_pkg::SAMPLE_W-1:0] delta;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0:       delta = '0;
				1, 2, 3: delta = $urandom_range(1000);
				4, 5:    delta = $urandom_range(32'h000F_FFFF);
				6, 7:    delta = $urandom;
				8:       delta = 32'hFFFF_FFFF - $urandom_range(15);
				default: delta = $urandom - counter_now;   // arbitrary jump
			endcase
			queue_sample(counter_now + delta, i == hold_at);
		end
	endtask

	// Change the idling pattern on a rising edge so the negedge drivers
	// never see it mid-update.
	task automatic set_idling(input int send_pct, input int stall_pct);
		@(posedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	// Block is idle once every queued sample has produced its result.
	task automatic wait_all_results();
		while (results_checked != items_queued)
			@(negedge clk);
	endtask

	task automatic write_frequency(input logic [tcus_pkg::FREQ_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.tick_frequency <= value;
		do @(negedge clk); while (!cfg_fired);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n                    = 1'b0;
		samples_ch.valid          = 1'b0;
		samples_ch.counter_sample = '0;
		results_ch.ready          = 1'b0;
		cfg_ch.valid              = 1'b0;
		cfg_ch.tick_frequency     = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Phase 0: reset frequency, no idling, directed corners then random
		set_idling(0, 0);
		queue_sample(32'hDEAD_BEEF);   // baseline only, nonzero vs reset prev
		queue_sample(32'hDEAD_BEEF);   // zero delta
		queue_sample(32'hFFFF_FFFF);
		queue_sample(32'h0000_0000);   // counter wraps by one
		queue_sample(32'h0000_0001);
		queue_sample(32'h8000_0000);
		queue_sample(32'h7FFF_FFFF);   // delta wraps to 2^32 - 1
		queue_sample(32'h7FFF_FFFE);   // maximum delta again
		queue_sample(32'h0000_0000);
		queue_sample(32'hFFFF_FFFF);
		queue_sample(32'hAAAA_AAAA);
		queue_sample(32'h5555_5555);
		queue_sample(32'h1234_5678);
		queue_random_samples(RANDOM_ITEMS, NO_DRAIN);
		wait_all_results();

		// Phase 1: lowest frequency, sender mostly idle
		write_frequency(32'd1);
		set_idling(84, 0);
		queue_random_samples(RANDOM_ITEMS, NO_DRAIN);
		wait_all_results();

		// Phase 2: highest frequency, receiver mostly stalled; one sample
		// waits for the pipeline to empty first
		write_frequency(32'hFFFF_FFFF);
		set_idling(0, 84);
		queue_random_samples(RANDOM_ITEMS, RANDOM_ITEMS / 2);
		wait_all_results();

		// Phase 3: zero written, block must fall back to the default rate
		write_frequency('0);
		set_idling(27, 27);
		queue_random_samples(RANDOM_ITEMS, RANDOM_ITEMS / 3);
		wait_all_results();

		// Phase 4: climb with maximum deltas
		write_frequency(32'd1_000_000);
		set_idling(0, 0);
		for (int i = 0; i < CLIMB_STEPS; i++)
			queue_sample(counter_now - 32'd1);
		wait_all_results();

		// Phase 5: random frequency on a large total
		write_frequency($urandom);
		set_idling(27, 27);
		queue_random_samples(RANDOM_ITEMS, NO_DRAIN);
		wait_all_results();

		// catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hang guard, several times the slowest legal run
	initial begin : watchdog
		#30_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/tcus_pkg.sv
rtl/tcus_if.sv
rtl/tcus_front.sv
rtl/tcus_fifo.sv
rtl/tcus_back.sv
rtl/tick_counter_to_microseconds.sv
test/tick_counter_to_microseconds_tb.sv
